// ===== src/rycc_pkg.sv =====
`default_nettype none

package rycc_pkg;

	localparam int FracBits = 16;
	localparam int ChromaOfs = 128;

	// Pixel payloads on the two channels
	typedef struct packed {
		logic [7:0] chan_first;
		logic [7:0] chan_second;
		logic [7:0] chan_third;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_first;
		logic [7:0] out_second;
		logic [7:0] out_third;
	} pix_out_t;

	// Q16 coefficient, wide enough for 115474
	typedef logic signed [17:0] coef_t;
	// Signed operand: channel value or chroma minus the offset
	typedef logic signed [9:0] opnd_t;
	// Accumulator: every sum stays within +/-2^25
	typedef logic signed [27:0] acc_t;

	localparam logic DIR_TO_YCC = 1'b0;
	localparam logic DIR_TO_RGB = 1'b1;

	// COEF[direction][output row][input column]
	localparam coef_t COEF [2][3][3] = '{
		'{
			'{18'sd19595, 18'sd38470, 18'sd7471},
			'{-18'sd11076, -18'sd21692, 18'sd32768},
			'{18'sd32768, -18'sd27460, -18'sd5308}
		},
		'{
			'{18'sd65536, 18'sd0, 18'sd91750},
			'{18'sd65536, -18'sd22479, -18'sd46596},
			'{18'sd65536, 18'sd115474, 18'sd0}
		}
	};

	localparam acc_t OFS_Q16 = acc_t'(ChromaOfs) <<< FracBits;

	// Offset added to each row's sum, per direction
	localparam acc_t ROW_OFS [2][3] = '{
		'{acc_t'(0), OFS_Q16, OFS_Q16},
		'{acc_t'(0), acc_t'(0), acc_t'(0)}
	};

endpackage

`default_nettype wire

// ===== src/rgb_ycbcr_color_convert_top.sv =====
// BT.601 full-range colour space converter, one pixel per clock when not stalled.
// Source channel: src_valid / src_stall / src_pix carry one pixel of three
// 8-bit channels; a transfer happens on a rising edge with valid high and
// stall low. Destination channel: dst_valid / dst_stall / dst_pix return
// the converted pixel, saturated to 0..255, in the same order.
// cfg_we / cfg_wdata write the direction bit: 0 converts RGB to YCbCr,
// 1 converts YCbCr to RGB. Write it only while no pixel is in flight.
// Two register stages lie between the ports: the input register and the
// result register. Throughput: one pixel per cycle while the destination
// does not stall; set by the single pass of constant multiply-adds between
// the two registers.
// Stall: while the result register is held by dst_stall, the input
// register may still take one more pixel; only when both are full and
// the destination stalls does src_stall rise.
// Reset (arst_n low, asynchronous): both stages empty, direction 0.
`default_nettype none

module rgb_ycbcr_color_convert_top
	import rycc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	input  wire logic     src_valid,
	output logic          src_stall,
	input  wire pix_in_t  src_pix,
	output logic          dst_valid,
	input  wire logic     dst_stall,
	output pix_out_t      dst_pix
);

	logic     dir_q;
	logic     valid_s1;
	pix_in_t  pix_s1;
	logic     valid_s2;
	pix_out_t res_s2;
	pix_out_t res_comb;
	logic     adv;
	logic     src_xfer;

	// Hold the direction bit; only bit 0 of the register exists
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_TO_YCC;
		end else if (cfg_we) begin
			dir_q <= cfg_wdata;
		end
	end

	// Advance stage 1 into the result register when that register is free
	// or its pixel is leaving this cycle
	assign adv       = valid_s1 && (!valid_s2 || !dst_stall);
	assign src_stall = valid_s1 && !adv;
	assign src_xfer  = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_xfer) begin
			pix_s1 <= src_pix;
		end
	end

	rycc_core u_core (
		.dir (dir_q),
		.pix (pix_s1),
		.res (res_comb)
	);

	// Drop the result once the destination takes it, unless a new one follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!dst_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign dst_valid = valid_s2;
	assign dst_pix   = res_s2;

	// Stalling the source needs both stages full and the destination stalled
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (valid_s1 && valid_s2 && dst_stall))
		else $error("source stalled with room in the pipeline");

	// An empty input register always takes a pixel
	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !src_stall)
		else $error("source stalled with empty input register");

	// A transfer on the source fills stage 1
	a_xfer_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		src_xfer |=> valid_s1)
		else $error("accepted pixel lost from stage 1");

	// An advance always leaves a result waiting at the destination
	a_adv_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> dst_valid)
		else $error("advanced pixel lost from result register");

	// A result held by the destination keeps its value
	a_held_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dst_stall) |=> (valid_s2 && $stable(res_s2)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== src/rycc_core.sv =====
`default_nettype none

module rycc_core
	import rycc_pkg::*;
(
	input  wire logic     dir,
	input  wire pix_in_t  pix,
	output pix_out_t      res
);

	opnd_t x [3];
	acc_t  prod [3][3];
	acc_t  acc [3];
	logic [7:0] sat [3];

	// Chroma inputs are centred on zero for the inverse direction
	always_comb begin
		x[0] = opnd_t'({2'b00, pix.chan_first});
		if (dir == DIR_TO_RGB) begin
			x[1] = opnd_t'({2'b00, pix.chan_second}) - opnd_t'(ChromaOfs);
			x[2] = opnd_t'({2'b00, pix.chan_third}) - opnd_t'(ChromaOfs);
		end else begin
			x[1] = opnd_t'({2'b00, pix.chan_second});
			x[2] = opnd_t'({2'b00, pix.chan_third});
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			assign prod[r][c] = acc_t'(COEF[dir][r][c]) * acc_t'(x[c]);
		end
		assign acc[r] = prod[r][0] + prod[r][1] + prod[r][2] + ROW_OFS[dir][r];

		// Floor by 16 bits, clamp to 0..255
		always_comb begin
			if (acc[r][27]) begin
				sat[r] = 8'd0;
			end else if (|acc[r][26:24]) begin
				sat[r] = 8'hFF;
			end else begin
				sat[r] = acc[r][23:16];
			end
		end
	end

	assign res.out_first  = sat[0];
	assign res.out_second = sat[1];
	assign res.out_third  = sat[2];

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

import rycc_pkg::*;

// Keeps the expected converted pixels in transfer order and checks each one
// that the destination side accepts.
class colour_scoreboard;
	localparam longint Q16_ONE = 65536;
	localparam longint CHROMA_Q16 = 128 * 65536;

	logic direction = DIR_TO_YCC;
	pix_out_t expected_q[$];
	int unsigned errors = 0;
	int unsigned checked = 0;
	int unsigned to_ycc_count = 0;
	int unsigned to_rgb_count = 0;

	static function logic [7:0] sat_q16(longint acc);
		longint q;
		if (acc < 0) begin
			return 8'd0;
		end
		q = acc >>> 16;
		if (q > 255) begin
			return 8'd255;
		end
		return q[7:0];
	endfunction

	function pix_out_t convert(pix_in_t p);
		longint a;
		longint b;
		longint c;
		pix_out_t r;
		a = p.chan_first;
		b = p.chan_second;
		c = p.chan_third;
		if (direction == DIR_TO_YCC) begin
			r.out_first  = sat_q16(19595 * a + 38470 * b + 7471 * c);
			r.out_second = sat_q16(-11076 * a - 21692 * b + 32768 * c + CHROMA_Q16);
			r.out_third  = sat_q16(32768 * a - 27460 * b - 5308 * c + CHROMA_Q16);
		end else begin
			r.out_first  = sat_q16(Q16_ONE * a + 91750 * (c - 128));
			r.out_second = sat_q16(Q16_ONE * a - 22479 * (b - 128) - 46596 * (c - 128));
			r.out_third  = sat_q16(Q16_ONE * a + 115474 * (b - 128));
		end
		return r;
	endfunction

	function void note_input(pix_in_t p);
		expected_q.push_back(convert(p));
		if (direction == DIR_TO_YCC) begin
			to_ycc_count++;
		end else begin
			to_rgb_count++;
		end
	endfunction

	function void check_result(pix_out_t got);
		pix_out_t want;
		if (expected_q.size() == 0) begin
			$error("result %h arrived with no pixel outstanding", got);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		checked++;
		if (got.out_first !== want.out_first) begin
			$error("out_first: expected %0d, got %0d", want.out_first, got.out_first);
			errors++;
		end
		if (got.out_second !== want.out_second) begin
			$error("out_second: expected %0d, got %0d", want.out_second, got.out_second);
			errors++;
		end
		if (got.out_third !== want.out_third) begin
			$error("out_third: expected %0d, got %0d", want.out_third, got.out_third);
			errors++;
		end
	endfunction

	function int outstanding();
		return expected_q.size();
	endfunction
endclass

module tb_top;
	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_we = 1'b0;
	logic     cfg_wdata = 1'b0;
	logic     src_valid = 1'b0;
	logic     src_stall;
	pix_in_t  src_pix = '0;
	logic     dst_valid;
	logic     dst_stall = 1'b0;
	pix_out_t dst_pix;

	// Set during a stretch of the random traffic: neither side idles then
	bit quiet = 1'b0;
	int unsigned dir_writes = 0;

	colour_scoreboard conv_sb;

	rgb_ycbcr_color_convert_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_pix   (src_pix),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_pix   (dst_pix)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Watchdog: the slowest correct run needs well under a tenth of this
	initial begin
		#4_000_000;
		$display("rgb_ycbcr_color_convert_top: mismatch");
		$finish;
	end

	// Sample both channels at the edge itself. Every input is driven with
	// nonblocking assignments and the outputs settle from registers, so the
	// values seen here are the ones the edge acted on. Note the input before
	// checking the output; a pixel never leaves on the edge it arrives.
	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				conv_sb.note_input(src_pix);
			end
			if (dst_valid && !dst_stall) begin
				conv_sb.check_result(dst_pix);
			end
		end
	end

	// Destination back-pressure: stall about one edge in five, never while quiet
	always @(posedge clk) begin
		dst_stall <= !quiet && ($urandom_range(99) < 19);
	end

	function automatic pix_in_t px(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		pix_in_t p;
		p.chan_first  = a;
		p.chan_second = b;
		p.chan_third  = c;
		return p;
	endfunction

	// Bias towards the edges of the range and the chroma midpoint, where the
	// saturation and sign changes live; the rest is uniform.
	function automatic logic [7:0] pick_channel();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(140, 116));
			3: return 8'($urandom_range(255, 230));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Offer one pixel, idling first at random, and hold it until the transfer
	task automatic send_pixel(input pix_in_t p);
		while (!quiet && ($urandom_range(99) < 19)) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_pix   <= p;
		@(posedge clk);
		while (src_stall) begin
			@(posedge clk);
		end
	endtask

	// Drain the pipeline, then write the direction bit while nothing is in flight
	task automatic set_direction(input logic dir);
		src_valid <= 1'b0;
		while (conv_sb.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= dir;
		@(posedge clk);
		cfg_we <= 1'b0;
		conv_sb.direction = dir;
		dir_writes++;
	endtask

	task automatic send_random(input int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			send_pixel(px(pick_channel(), pick_channel(), pick_channel()));
		end
	endtask

	initial begin
		int unsigned spins;
		conv_sb = new;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// RGB to YCbCr: black, white, primaries, yellow, alternating bit patterns, grey
		set_direction(DIR_TO_YCC);
		send_pixel(px(8'h00, 8'h00, 8'h00));
		send_pixel(px(8'hff, 8'hff, 8'hff));
		send_pixel(px(8'hff, 8'h00, 8'h00));
		send_pixel(px(8'h00, 8'hff, 8'h00));
		send_pixel(px(8'h00, 8'h00, 8'hff));
		send_pixel(px(8'hff, 8'hff, 8'h00));
		send_pixel(px(8'haa, 8'h55, 8'haa));
		send_pixel(px(8'h55, 8'haa, 8'h55));
		send_pixel(px(8'h80, 8'h80, 8'h80));

		// YCbCr to RGB: neutral greys, sums that go negative, sums past 255
		set_direction(DIR_TO_RGB);
		send_pixel(px(8'h00, 8'h80, 8'h80));
		send_pixel(px(8'hff, 8'h80, 8'h80));
		send_pixel(px(8'hff, 8'hff, 8'hff));
		send_pixel(px(8'h00, 8'h00, 8'h00));
		send_pixel(px(8'hff, 8'h00, 8'hff));
		send_pixel(px(8'h00, 8'hff, 8'h00));
		send_pixel(px(8'h80, 8'h00, 8'h80));
		send_pixel(px(8'h80, 8'hff, 8'h80));
		send_pixel(px(8'h80, 8'h80, 8'h00));
		send_pixel(px(8'h80, 8'h80, 8'hff));
		send_pixel(px(8'haa, 8'h55, 8'haa));
		send_pixel(px(8'h55, 8'haa, 8'h55));

		// Random traffic, flipping direction between phases; the third phase
		// runs with neither side idling
		for (int ph = 0; ph < 6; ph++) begin
			set_direction((ph % 2) == 0 ? DIR_TO_YCC : DIR_TO_RGB);
			quiet = (ph == 2);
			send_random(230);
			quiet = 1'b0;
		end
		src_valid <= 1'b0;

		// Wait for the last results, with a limit, then a few edges for strays
		spins = 0;
		while (conv_sb.outstanding() != 0 && spins < 2000) begin
			@(posedge clk);
			spins++;
		end
		repeat (5) @(posedge clk);

		$display("Checked %0d pixels: %0d RGB to YCbCr, %0d YCbCr to RGB, %0d direction writes",
			conv_sb.checked, conv_sb.to_ycc_count, conv_sb.to_rgb_count, dir_writes);
		$display("Both sides idled at random, with one stretch of back-to-back transfers");
		if (conv_sb.errors == 0 && conv_sb.outstanding() == 0) begin
			$display("rgb_ycbcr_color_convert_top: match");
		end else begin
			if (conv_sb.outstanding() != 0) begin
				$error("%0d expected pixels never arrived", conv_sb.outstanding());
			end
			$display("rgb_ycbcr_color_convert_top: mismatch");
		end
		$finish;
	end
endmodule

// ===== files.f =====
src/rycc_pkg.sv
src/rycc_core.sv
src/rgb_ycbcr_color_convert_top.sv
bench/tb_top.sv
